### src/upd_pkg.sv
// ----------------------------------------------------------------------------
// URL percent decoder package
// Shared types, character codes, mode codes and decode helper functions.
// ----------------------------------------------------------------------------
package upd_pkg;

  // Character codes used by the decoder.
  localparam logic [7:0] CHAR_PCT   = 8'h25;  // '%'
  localparam logic [7:0] CHAR_SLASH = 8'h2F;  // '/'
  localparam logic [7:0] CHAR_NINE  = 8'h39;  // '9'

  // Unescape mode codes; the unused code behaves like MODE_ALL.
  localparam logic [1:0] MODE_RESERVED = 2'd0;
  localparam logic [1:0] MODE_SLASH    = 2'd1;
  localparam logic [1:0] MODE_ALL      = 2'd2;

  // Configuration address map.
  localparam int unsigned CFG_ADDR_W = 3;
  localparam logic REG_UNESCAPE_MODE = 1'b0;

  // What is held between bytes: nothing, a '%', or a '%' and one hex digit.
  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_PCT  = 2'd1,
    PEND_HEX  = 2'd2
  } pend_t;

  // Result group produced by one input byte: up to three output bytes.
  // The last mark belongs to the final byte of the group only.
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
    logic       last;
  } grp_t;

  function automatic logic is_hex(input logic [7:0] c);
    logic r;
    case (c) inside
      [8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66]: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Nibble value of a hex digit; letters are lifted by nine.
  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] x;
    x = c;
    if (c > CHAR_NINE) begin
      x = c + 8'd9;
    end
    return x[3:0];
  endfunction

  // Reserved characters: ! # $ & ' ( ) * + , / : ; = ? @ [ ]
  function automatic logic is_reserved(input logic [7:0] c);
    logic r;
    case (c) inside
      8'h21, 8'h23, 8'h24, 8'h26, 8'h27, 8'h28, 8'h29, 8'h2A, 8'h2B,
      8'h2C, 8'h2F, 8'h3A, 8'h3B, 8'h3D, 8'h3F, 8'h40, 8'h5B, 8'h5D: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_excluded(input logic [7:0] c, input logic [1:0] mode);
    logic r;
    case (mode)
      MODE_RESERVED: r = is_reserved(c);
      MODE_SLASH:    r = (c == CHAR_SLASH);
      default:       r = 1'b0;
    endcase
    return r;
  endfunction

endpackage

### src/upd_stream_if.sv
// ----------------------------------------------------------------------------
// URL percent decoder stream interfaces
// Valid/ready byte channels for the raw input and the decoded output.
// ----------------------------------------------------------------------------
interface upd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface upd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;

  modport source (output valid, output out_byte, output out_last, input ready);
  modport sink   (input valid, input out_byte, input out_last, output ready);
endinterface

### src/url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// URL percent decoder top level
// Streaming percent-decoder with an APB-style mode register.
// ----------------------------------------------------------------------------
// Raw string bytes enter on in_chan with a last mark on the final byte, and
// decoded bytes leave on out_chan. A '%' and two hex digits become one byte
// unless the mode register keeps that byte escaped (0: reserved characters,
// 1: only '/', 2 or 3: nothing); otherwise the '%' passes as a literal. Each
// input byte is decoded in the cycle it is accepted and its results, zero to
// three bytes, go into an output register group that drains one byte per
// cycle while out_chan is ready, starting in the cycle after acceptance. A
// byte is accepted every cycle while each yields at most one result and
// out_chan is ready; after a longer group the next byte is taken in the cycle
// its last result leaves. The user must write the mode only while the decoder
// is idle; the block itself does not enforce it.
module url_percent_decoder_top (
  input  logic                           clk,
  input  logic                           rst_n,
  upd_in_if.sink                         in_chan,
  upd_out_if.source                      out_chan,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [upd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready
);

  logic          accept;
  logic          load_ok;
  logic [1:0]    mode;
  upd_pkg::grp_t grp;

  assign in_chan.ready = load_ok;
  assign accept        = in_chan.valid && load_ok;

  // Configuration registers.
  upd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .mode    (mode)
  );

  // Escape tracking and decode.
  upd_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .in_byte (in_chan.in_byte),
    .in_last (in_chan.in_last),
    .mode    (mode),
    .grp     (grp)
  );

  // Result register and serializer.
  upd_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .grp       (grp),
    .load_ok   (load_ok),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .out_byte  (out_chan.out_byte),
    .out_last  (out_chan.out_last)
  );

endmodule

### src/upd_cfg.sv
// ----------------------------------------------------------------------------
// URL percent decoder configuration registers
// APB-style register port holding the unescape mode.
// ----------------------------------------------------------------------------
module upd_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [upd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  output logic [1:0]                     mode
);

  logic [1:0] mode_r;
  logic       sel_mode;
  logic       wr_en;

  assign pready   = 1'b1;
  assign sel_mode = (paddr[upd_pkg::CFG_ADDR_W-1] == upd_pkg::REG_UNESCAPE_MODE);
  assign wr_en    = psel && penable && pwrite && pready;

  // Mode register write.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= upd_pkg::MODE_RESERVED;
    end else if (wr_en && sel_mode) begin
      mode_r <= pwdata[1:0];
    end
  end

  // Read back; addresses with the top bit set read as zero.
  always_comb begin
    prdata = 32'd0;
    if (sel_mode) begin
      prdata = {30'd0, mode_r};
    end
  end

  assign mode = mode_r;

endmodule

### src/upd_core.sv
// ----------------------------------------------------------------------------
// URL percent decoder core
// Holds the pending escape and turns each input byte into a result group.
// ----------------------------------------------------------------------------
module upd_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          accept,
  input  logic [7:0]    in_byte,
  input  logic          in_last,
  input  logic [1:0]    mode,
  output upd_pkg::grp_t grp
);

  upd_pkg::pend_t pend_r;
  upd_pkg::pend_t pend_nxt;
  logic [7:0]     hex_r;
  logic [7:0]     hex_nxt;
  logic           starts;
  logic           digit;
  logic [7:0]     decoded;
  logic           dec_ok;

  // A '%' that is not the final byte opens a new escape.
  assign starts  = (in_byte == upd_pkg::CHAR_PCT) && !in_last;
  assign digit   = upd_pkg::is_hex(in_byte);
  assign decoded = {upd_pkg::hex_val(hex_r), upd_pkg::hex_val(in_byte)};
  assign dec_ok  = digit && !upd_pkg::is_excluded(decoded, mode);

  // Next pending state.
  always_comb begin
    hex_nxt = hex_r;
    case (pend_r)
      upd_pkg::PEND_PCT: begin
        if (digit && !in_last) begin
          pend_nxt = upd_pkg::PEND_HEX;
          hex_nxt  = in_byte;
        end else begin
          pend_nxt = starts ? upd_pkg::PEND_PCT : upd_pkg::PEND_NONE;
        end
      end
      upd_pkg::PEND_HEX: begin
        if (dec_ok) begin
          pend_nxt = upd_pkg::PEND_NONE;
        end else begin
          pend_nxt = starts ? upd_pkg::PEND_PCT : upd_pkg::PEND_NONE;
        end
      end
      default: begin
        pend_nxt = starts ? upd_pkg::PEND_PCT : upd_pkg::PEND_NONE;
      end
    endcase
  end

  // Result group for the byte; the last mark always follows the input mark.
  always_comb begin
    grp      = '0;
    grp.b0   = in_byte;
    grp.b1   = in_byte;
    grp.b2   = in_byte;
    grp.last = in_last;
    case (pend_r)
      upd_pkg::PEND_PCT: begin
        if (!(digit && !in_last)) begin
          grp.b0  = upd_pkg::CHAR_PCT;
          grp.cnt = starts ? 2'd1 : 2'd2;
        end
      end
      upd_pkg::PEND_HEX: begin
        if (dec_ok) begin
          grp.b0  = decoded;
          grp.cnt = 2'd1;
        end else begin
          grp.b0  = upd_pkg::CHAR_PCT;
          grp.b1  = hex_r;
          grp.cnt = starts ? 2'd2 : 2'd3;
        end
      end
      default: begin
        grp.cnt = starts ? 2'd0 : 2'd1;
      end
    endcase
  end

  // Pending state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= upd_pkg::PEND_NONE;
      hex_r  <= 8'd0;
    end else if (accept) begin
      pend_r <= pend_nxt;
      hex_r  <= hex_nxt;
    end
  end

  // Nothing stays held once a string ends.
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_last |=> pend_r == upd_pkg::PEND_NONE)
    else $error("pending escape survived the end of a string");

  // A held byte is never dropped: a silent byte must move into the pending state.
  a_silent_holds: assert property (@(posedge clk) disable iff (!rst_n)
    accept && grp.cnt == 2'd0 |=> pend_r != upd_pkg::PEND_NONE)
    else $error("byte swallowed without being held");

  // A successful decode closes the escape.
  a_decode_closes: assert property (@(posedge clk) disable iff (!rst_n)
    accept && pend_r == upd_pkg::PEND_HEX && dec_ok |=> pend_r == upd_pkg::PEND_NONE)
    else $error("escape still pending after decode");

endmodule

### src/upd_outq.sv
// ----------------------------------------------------------------------------
// URL percent decoder output queue
// Registers a result group and hands it out one byte per transaction.
// ----------------------------------------------------------------------------
module upd_outq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  upd_pkg::grp_t grp,
  output logic          load_ok,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          out_last
);

  logic [1:0] cnt_r;
  logic [1:0] cnt_nxt;
  logic [7:0] b0_r;
  logic [7:0] b1_r;
  logic [7:0] b2_r;
  logic       last_r;
  logic       pop;

  assign out_valid = (cnt_r != 2'd0);
  assign pop       = out_valid && out_ready;
  // A new group may enter once the current one is gone or leaves this cycle.
  assign load_ok   = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);
  assign out_byte  = b0_r;
  assign out_last  = last_r && (cnt_r == 2'd1);

  always_comb begin
    if (load) begin
      cnt_nxt = grp.cnt;
    end else if (pop) begin
      cnt_nxt = cnt_r - 2'd1;
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  // Byte count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  // Group bytes shift toward the head on each transaction.
  always_ff @(posedge clk) begin
    if (load) begin
      b0_r   <= grp.b0;
      b1_r   <= grp.b1;
      b2_r   <= grp.b2;
      last_r <= grp.last;
    end else if (pop) begin
      b0_r <= b1_r;
      b1_r <= b2_r;
    end
  end

  // A multi-byte group drains one byte per transaction.
  a_drain_step: assert property (@(posedge clk) disable iff (!rst_n)
    pop && cnt_r > 2'd1 |=> cnt_r == $past(cnt_r) - 2'd1)
    else $error("group count did not step down");

  // A loaded group with bytes is offered on the next cycle.
  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    load && grp.cnt != 2'd0 |=> out_valid)
    else $error("loaded group not offered");

endmodule

### test/upd_stream_checker.sv
// ----------------------------------------------------------------------------
// URL percent decoder stream checker
// Watches the raw and decoded byte channels and the mode register port. It
// keeps its own copy of the decoder state, works out the decoded bytes that
// each accepted raw byte must release, and compares them in order with the
// bytes that leave the block.
// ----------------------------------------------------------------------------
module upd_stream_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  upd_in_if                              in_mon,
  upd_out_if                             out_mon,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic                           pready,
  input  logic [upd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                    pwdata,
  output int                             mismatches,
  output int                             bytes_checked,
  output int                             outstanding
);

  localparam logic [upd_pkg::CFG_ADDR_W-1:0] MODE_ADDR = {upd_pkg::REG_UNESCAPE_MODE, 2'b00};

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } dec_byte_t;

  // Shadow of the decoder: mode register and what is held between bytes.
  logic [1:0]     mode_shadow;
  upd_pkg::pend_t held;
  logic [7:0]     held_digit;

  // Decoded bytes still owed by the block, oldest first.
  dec_byte_t  owed_q[$];
  dec_byte_t  oldest;

  initial begin
    mismatches    = 0;
    bytes_checked = 0;
    outstanding   = 0;
  end

  // Prints one line per mismatch and counts it.
  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("ERROR %0t: %s", $time, msg);
  endtask

  function automatic logic hex_digit_char(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] v;
    if (c <= "9") begin
      v = c - "0";
    end else begin
      v = (c | 8'h20) - "a" + 8'd10;
    end
    return v[3:0];
  endfunction

  // RFC 6570 reserved set, kept escaped in the reserved mode.
  function automatic logic reserved_char(input logic [7:0] c);
    case (c)
      "!", "#", "$", "&", "'", "(", ")", "*", "+",
      ",", "/", ":", ";", "=", "?", "@", "[", "]": return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic kept_escaped(input logic [7:0] c);
    if (mode_shadow == upd_pkg::MODE_RESERVED) begin
      return reserved_char(c);
    end else if (mode_shadow == upd_pkg::MODE_SLASH) begin
      return c == upd_pkg::CHAR_SLASH;
    end
    return 1'b0;
  endfunction

  function automatic void owe_byte(input logic [7:0] data, input logic last);
    dec_byte_t d;
    d.data = data;
    d.last = last;
    owed_q.push_back(d);
  endfunction

  // A byte seen with nothing held: a '%' that is not the last byte is held.
  function automatic void scan_free(input logic [7:0] b, input logic last);
    if (b == upd_pkg::CHAR_PCT && !last) begin
      held = upd_pkg::PEND_PCT;
    end else begin
      held = upd_pkg::PEND_NONE;
      owe_byte(b, last);
    end
  endfunction

  // Works out the decoded bytes released by one raw byte.
  function automatic void decode_raw_byte(input logic [7:0] b, input logic last);
    logic [7:0] value;
    value = {digit_value(held_digit), digit_value(b)};
    case (held)
      upd_pkg::PEND_PCT: begin
        if (hex_digit_char(b) && !last) begin
          held_digit = b;
          held       = upd_pkg::PEND_HEX;
        end else begin
          owe_byte(upd_pkg::CHAR_PCT, 1'b0);
          scan_free(b, last);
        end
      end
      upd_pkg::PEND_HEX: begin
        if (hex_digit_char(b) && !kept_escaped(value)) begin
          held = upd_pkg::PEND_NONE;
          owe_byte(value, last);
        end else begin
          // Not an escape we may decode: the held bytes pass as literals.
          owe_byte(upd_pkg::CHAR_PCT, 1'b0);
          owe_byte(held_digit, 1'b0);
          scan_free(b, last);
        end
      end
      default: scan_free(b, last);
    endcase
  endfunction

  // Everything is sampled on the rising edge, before the edge's updates land.
  always @(posedge clk) begin
    if (!rst_n) begin
      mode_shadow = upd_pkg::MODE_RESERVED;
      held        = upd_pkg::PEND_NONE;
      held_digit  = 8'h00;
      owed_q.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == MODE_ADDR) begin
        mode_shadow = pwdata[1:0];
      end

      // Each decoded transaction must match the oldest owed byte.
      if (out_mon.valid && out_mon.ready) begin
        if (owed_q.size() == 0) begin
          report_mismatch($sformatf("decoded byte %h last %b with nothing owed",
                                    out_mon.out_byte, out_mon.out_last));
        end else begin
          oldest = owed_q.pop_front();
          bytes_checked++;
          if (out_mon.out_byte !== oldest.data) begin
            report_mismatch($sformatf("out_byte %h, expected %h",
                                      out_mon.out_byte, oldest.data));
          end
          if (out_mon.out_last !== oldest.last) begin
            report_mismatch($sformatf("out_last %b on byte %h, expected %b",
                                      out_mon.out_last, out_mon.out_byte, oldest.last));
          end
        end
      end

      if (in_mon.valid && in_mon.ready) begin
        decode_raw_byte(in_mon.in_byte, in_mon.in_last);
      end
    end
    outstanding = owed_q.size();
  end

endmodule

### test/tb_url_percent_decoder_top.sv
// ----------------------------------------------------------------------------
// URL percent decoder testbench
// Drives escaped strings into the decoder under every mode code, with random
// gaps on the raw side and random stalls on the decoded side. A checker
// beside the block predicts and compares the decoded stream.
// ----------------------------------------------------------------------------
module tb_url_percent_decoder_top;

  localparam logic [upd_pkg::CFG_ADDR_W-1:0] MODE_ADDR = {upd_pkg::REG_UNESCAPE_MODE, 2'b00};
  // The unused mode code, which must behave like MODE_ALL.
  localparam logic [1:0]            MODE_SPARE    = 2'd3;
  localparam int                    PHASE_BYTES   = 60;
  localparam int                    NUM_PHASES    = 5;
  localparam int                    DRAIN_CYCLES  = 8;
  localparam int                    STALL_LIMIT   = 1000;

  localparam logic [7:0] RESERVED_SET [18] = '{
    "!", "#", "$", "&", "'", "(", ")", "*", "+",
    ",", "/", ":", ";", "=", "?", "@", "[", "]"
  };
  localparam logic [1:0] PHASE_MODES [NUM_PHASES] = '{
    upd_pkg::MODE_SLASH, upd_pkg::MODE_ALL, MODE_SPARE, upd_pkg::MODE_RESERVED,
    upd_pkg::MODE_SLASH
  };

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [upd_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int          mismatches;
  int          bytes_checked;
  int          outstanding;
  int          raw_sent;
  int          strings_sent;
  int          idle_cycles;
  int          sink_hold;
  bit          source_quiet;
  bit          sink_quiet;
  logic [7:0]  string_q[$];

  upd_in_if  in_chan();
  upd_out_if out_chan();

  url_percent_decoder_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  upd_stream_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .mismatches    (mismatches),
    .bytes_checked (bytes_checked),
    .outstanding   (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Decoded side: mostly ready, with short stalls and an occasional long one.
  always @(posedge clk) begin
    if (sink_hold > 0) begin
      out_chan.ready <= 1'b0;
      sink_hold      <= sink_hold - 1;
    end else begin
      out_chan.ready <= 1'b1;
      if (!sink_quiet && $urandom_range(0, 99) < 25) begin
        sink_hold <= ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(5, 25);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL url_percent_decoder_top");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (source_quiet || r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(5, 30);
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) begin
      return "0" + n;
    end else if ($urandom_range(0, 1) == 1) begin
      return "A" + n - 8'd10;
    end
    return "a" + n - 8'd10;
  endfunction

  // Decoded values lean toward the characters each mode keeps escaped.
  function automatic logic [7:0] pick_value();
    case ($urandom_range(0, 4))
      0: return RESERVED_SET[$urandom_range(0, 17)];
      1: return upd_pkg::CHAR_SLASH;
      2: return upd_pkg::CHAR_PCT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Sends one raw byte, after a random gap, and returns at its acceptance.
  task automatic send_raw(input logic [7:0] b, input logic last);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid   <= 1'b1;
    in_chan.in_byte <= b;
    in_chan.in_last <= last;
    do @(posedge clk); while (!in_chan.ready);
    raw_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      send_raw(s[i], i == s.len() - 1);
    end
    strings_sent++;
  endtask

  task automatic send_string_q();
    foreach (string_q[i]) begin
      send_raw(string_q[i], i == string_q.size() - 1);
    end
    strings_sent++;
  endtask

  // Builds a string of well-formed escapes, the likeliest token, with broken ones and noise.
  task automatic build_string();
    int         tokens;
    logic [7:0] v;
    string_q.delete();
    tokens = $urandom_range(1, 6);
    repeat (tokens) begin
      v = pick_value();
      case ($urandom_range(0, 9))
        0, 1, 2: string_q.push_back(8'($urandom_range(0, 255)));
        7: begin
          string_q.push_back(upd_pkg::CHAR_PCT);
          string_q.push_back(hex_char(v[7:4]));
          string_q.push_back(8'($urandom_range(0, 255)));
        end
        8: begin
          string_q.push_back(upd_pkg::CHAR_PCT);
          string_q.push_back(8'($urandom_range(0, 255)));
        end
        9: string_q.push_back(upd_pkg::CHAR_PCT);
        default: begin
          string_q.push_back(upd_pkg::CHAR_PCT);
          string_q.push_back(hex_char(v[7:4]));
          string_q.push_back(hex_char(v[3:0]));
        end
      endcase
    end
  endtask

  task automatic run_random(input int n);
    int sent;
    sent = 0;
    while (sent < n) begin
      build_string();
      source_quiet = ($urandom_range(0, 3) == 0);
      sink_quiet   = ($urandom_range(0, 4) == 0);
      send_string_q();
      sent += string_q.size();
    end
  endtask

  // Short directed strings: plain escapes, excluded escapes, bad digits,
  // strings that end inside an escape, and the byte extremes.
  task automatic run_directed();
    send_text("%41");
    send_text("%2f");
    send_text("%g");
    send_text("%%41");
    send_text("%4");
    send_text("%");
    send_text("%4g");
    send_text("%fF");
    send_text("%2F");
    send_raw(8'h00, 1'b0);
    send_raw(8'hFF, 1'b1);
    strings_sent++;
  endtask

  // Waits until every decoded byte has left and the block has gone quiet.
  task automatic settle();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    wait (outstanding == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Setup cycle, then an access cycle that completes while pready is high.
  task automatic write_mode(input logic [1:0] mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= MODE_ADDR;
    pwdata  <= {30'd0, mode};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Main sequence: reset, directed strings, then random phases per mode.
  initial begin
    rst_n           = 1'b0;
    psel            = 1'b0;
    penable         = 1'b0;
    pwrite          = 1'b0;
    paddr           = '0;
    pwdata          = '0;
    in_chan.valid   = 1'b0;
    in_chan.in_byte = 8'h00;
    in_chan.in_last = 1'b0;
    out_chan.ready  = 1'b0;
    raw_sent        = 0;
    strings_sent    = 0;
    idle_cycles     = 0;
    sink_hold       = 0;
    source_quiet    = 1'b0;
    sink_quiet      = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    run_directed();
    run_random(PHASE_BYTES);
    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_mode(PHASE_MODES[p]);
      run_random(PHASE_BYTES);
    end
    settle();

    $display("Sent %0d raw bytes in %0d strings under mode codes 0 to 3,", raw_sent,
             strings_sent);
    $display("with gaps and stalls on both channels; %0d decoded bytes checked.",
             bytes_checked);
    if (mismatches == 0) begin
      $display("PASS url_percent_decoder_top");
    end else begin
      $display("FAIL url_percent_decoder_top");
    end
    $finish;
  end

endmodule
